### sv/kmpc_pkg.sv
// Package for the keyed motor PWM controller: mode and command codes, register
// indexes, reset values and timing constants. No dependencies.
`default_nettype none

package kmpc_pkg;

	// Timing and sample constants
	localparam int TICKS_PER_MS    = 5;
	localparam int MS_PER_SECOND   = 1000;
	localparam int MEDIUM_BLINK_MS = 200;
	localparam int SLOW_BLINK_MS   = 500;
	localparam int ADC_BITS        = 10;

	localparam int LEVEL_W = 10;
	localparam int TIMEOUT_W = 16;
	localparam int DUTY_W = 8;
	localparam int MS_W = 10;
	localparam int DIV_W = 3;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 16;

	// Count of multiples of each blink period that fit in the millisecond counter
	localparam int MEDIUM_HITS = 1023 / MEDIUM_BLINK_MS + 1;
	localparam int SLOW_HITS   = 1023 / SLOW_BLINK_MS + 1;

	localparam logic [LEVEL_W-1:0] ADC_MASK = LEVEL_W'((1 << ADC_BITS) - 1);
	localparam logic [DUTY_W-1:0] DUTY_OFF = 8'hFF;
	localparam logic [TIMEOUT_W-1:0] SECONDS_MAX = 16'hFFFF;

	// Register reset values
	localparam logic [LEVEL_W-1:0] MODE_KEY_RST = 10'd605;
	localparam logic [LEVEL_W-1:0] FWD_KEY_RST = 10'd344;
	localparam logic [LEVEL_W-1:0] REV_KEY_RST = 10'd186;
	localparam logic [LEVEL_W-1:0] WINDOW_RST = 10'd50;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd360;
	localparam logic [DUTY_W-1:0] FAST_DUTY_RST = 8'h00;
	localparam logic [DUTY_W-1:0] MEDIUM_DUTY_RST = 8'h3F;
	localparam logic [DUTY_W-1:0] SLOW_DUTY_RST = 8'h7F;

	typedef enum logic [1:0] {
		SPEED_FAST   = 2'd0,
		SPEED_MEDIUM = 2'd1,
		SPEED_SLOW   = 2'd2
	} mode_t;

	typedef enum logic {
		CMD_TICK   = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE_KEY    = 4'd0,
		REG_FWD_KEY     = 4'd1,
		REG_REV_KEY     = 4'd2,
		REG_WINDOW      = 4'd3,
		REG_TIMEOUT     = 4'd4,
		REG_FAST_DUTY   = 4'd5,
		REG_MEDIUM_DUTY = 4'd6,
		REG_SLOW_DUTY   = 4'd7
	} reg_idx_t;

endpackage

`default_nettype wire

### sv/keyed_motor_pwm_controller_unit.sv
// Keyed motor PWM controller: input register, state update and result handshake.
// Depends on kmpc_pkg.
`default_nettype none

// Takes one item per cycle: a timer tick or a keypad ADC sample (s_tuser selects).
// Each item yields one result: it is held in the input register, then the state
// update is registered, and the result is taken straight from the state registers
// onto m_tdata. The only loop is the state update, so a stream of back-to-back
// items runs at one per cycle while m_tready stays high. Key levels, window, idle
// timeout and the three mode duties are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no item is in flight, which the block does
// not enforce; indexes above 7 are ignored. After reset the mode is medium, both
// duties are off (255) and the LED is dark.
module keyed_motor_pwm_controller_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [15:0] s_tdata,   // [9:0] adc_value, [15:10] zero
	input  wire logic [0:0]  s_tuser,   // [0] command (0 tick, 1 sample)
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [23:0] m_tdata,   // [7:0] forward_duty, [15:8] reverse_duty,
	                                    // [16] led_on, [17] power_off,
	                                    // [19:18] current_mode, [23:20] zero
	input  wire logic        cfg_we,
	input  wire logic [kmpc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [kmpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Configuration registers
	logic [kmpc_pkg::LEVEL_W-1:0]   mode_key_q, fwd_key_q, rev_key_q, window_q;
	logic [kmpc_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [kmpc_pkg::DUTY_W-1:0]    fast_duty_q, medium_duty_q, slow_duty_q;

	// Block state
	logic [kmpc_pkg::DIV_W-1:0]     tick_div_q;
	logic [kmpc_pkg::MS_W-1:0]      ms_q;
	logic [kmpc_pkg::TIMEOUT_W-1:0] idle_sec_q;
	kmpc_pkg::mode_t                mode_q;
	logic                           mode_held_q;
	logic [kmpc_pkg::DUTY_W-1:0]    fwd_cmp_q, rev_cmp_q;
	logic                           led_q, power_cut_q;

	// Input register and result handshake
	logic                         valid_s1;
	kmpc_pkg::cmd_t               cmd_s1;
	logic [kmpc_pkg::LEVEL_W-1:0] adc_s1;
	logic                         out_valid_q;
	logic                         advance;

	// Next-state values
	logic [kmpc_pkg::DIV_W-1:0]     tick_div_d;
	logic [kmpc_pkg::MS_W-1:0]      ms_d;
	logic [kmpc_pkg::TIMEOUT_W-1:0] idle_sec_d;
	kmpc_pkg::mode_t                mode_d;
	logic                           mode_held_d;
	logic [kmpc_pkg::DUTY_W-1:0]    fwd_cmp_d, rev_cmp_d;
	logic                           led_d, power_cut_d;

	logic [kmpc_pkg::LEVEL_W-1:0] sample;
	logic                         hit_mode, hit_fwd, hit_rev;
	logic                         medium_hit, slow_hit;
	logic [kmpc_pkg::DUTY_W-1:0]  mode_duty;

	function automatic logic key_match(
		input logic [kmpc_pkg::LEVEL_W-1:0] s,
		input logic [kmpc_pkg::LEVEL_W-1:0] level,
		input logic [kmpc_pkg::LEVEL_W-1:0] window
	);
		logic [kmpc_pkg::LEVEL_W-1:0] span;
		span = (s >= level) ? (s - level) : (level - s);
		return span <= window;
	endfunction

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, mode_q, power_cut_q, led_q, rev_cmp_q, fwd_cmp_q};

	assign sample   = adc_s1 & kmpc_pkg::ADC_MASK;
	assign hit_mode = key_match(sample, mode_key_q, window_q);
	assign hit_fwd  = key_match(sample, fwd_key_q, window_q);
	assign hit_rev  = key_match(sample, rev_key_q, window_q);

	// Duty of the mode after any mode step on this sample
	always_comb begin
		unique case (mode_d)
			kmpc_pkg::SPEED_FAST:   mode_duty = fast_duty_q;
			kmpc_pkg::SPEED_MEDIUM: mode_duty = medium_duty_q;
			default:                mode_duty = slow_duty_q;
		endcase
	end

	// Blink points: the incremented count equals a multiple of the blink period
	always_comb begin
		logic [kmpc_pkg::MS_W-1:0] ms_inc;
		ms_inc = ms_q + 1'b1;
		medium_hit = 1'b0;
		slow_hit = 1'b0;
		for (int k = 0; k < kmpc_pkg::MEDIUM_HITS; k++) begin
			if (ms_inc == kmpc_pkg::MS_W'(k * kmpc_pkg::MEDIUM_BLINK_MS))
				medium_hit = 1'b1;
		end
		for (int k = 0; k < kmpc_pkg::SLOW_HITS; k++) begin
			if (ms_inc == kmpc_pkg::MS_W'(k * kmpc_pkg::SLOW_BLINK_MS))
				slow_hit = 1'b1;
		end
	end

	always_comb begin
		logic [kmpc_pkg::DIV_W-1:0] div_inc;
		div_inc     = tick_div_q + 1'b1;
		tick_div_d  = tick_div_q;
		ms_d        = ms_q;
		idle_sec_d  = idle_sec_q;
		mode_d      = mode_q;
		mode_held_d = mode_held_q;
		fwd_cmp_d   = fwd_cmp_q;
		rev_cmp_d   = rev_cmp_q;
		led_d       = led_q;
		power_cut_d = power_cut_q;
		if (cmd_s1 == kmpc_pkg::CMD_SAMPLE) begin
			if (hit_mode) begin
				if (!mode_held_q) begin
					unique case (mode_q)
						kmpc_pkg::SPEED_FAST:   mode_d = kmpc_pkg::SPEED_MEDIUM;
						kmpc_pkg::SPEED_MEDIUM: mode_d = kmpc_pkg::SPEED_SLOW;
						default:                mode_d = kmpc_pkg::SPEED_FAST;
					endcase
				end
				mode_held_d = 1'b1;
			end else begin
				mode_held_d = 1'b0;
			end
			// Forward wins when both drive windows match
			priority if (hit_fwd) begin
				fwd_cmp_d  = mode_duty;
				idle_sec_d = '0;
			end else if (hit_rev) begin
				rev_cmp_d  = mode_duty;
				idle_sec_d = '0;
			end else begin
				fwd_cmp_d = kmpc_pkg::DUTY_OFF;
				rev_cmp_d = kmpc_pkg::DUTY_OFF;
			end
		end else begin
			tick_div_d = div_inc;
			if (div_inc >= kmpc_pkg::DIV_W'(kmpc_pkg::TICKS_PER_MS)) begin
				tick_div_d = '0;
				ms_d = ms_q + 1'b1;
				unique case (mode_q)
					kmpc_pkg::SPEED_FAST:   led_d = 1'b1;
					kmpc_pkg::SPEED_MEDIUM: led_d = led_q ^ medium_hit;
					default:                led_d = led_q ^ slow_hit;
				endcase
			end
			if (ms_d >= kmpc_pkg::MS_W'(kmpc_pkg::MS_PER_SECOND)) begin
				ms_d = '0;
				if (idle_sec_q != kmpc_pkg::SECONDS_MAX)
					idle_sec_d = idle_sec_q + 1'b1;
			end
			if (idle_sec_d >= timeout_q)
				power_cut_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_key_q    <= kmpc_pkg::MODE_KEY_RST;
			fwd_key_q     <= kmpc_pkg::FWD_KEY_RST;
			rev_key_q     <= kmpc_pkg::REV_KEY_RST;
			window_q      <= kmpc_pkg::WINDOW_RST;
			timeout_q     <= kmpc_pkg::TIMEOUT_RST;
			fast_duty_q   <= kmpc_pkg::FAST_DUTY_RST;
			medium_duty_q <= kmpc_pkg::MEDIUM_DUTY_RST;
			slow_duty_q   <= kmpc_pkg::SLOW_DUTY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kmpc_pkg::REG_MODE_KEY:    mode_key_q <= cfg_data[kmpc_pkg::LEVEL_W-1:0];
				kmpc_pkg::REG_FWD_KEY:     fwd_key_q <= cfg_data[kmpc_pkg::LEVEL_W-1:0];
				kmpc_pkg::REG_REV_KEY:     rev_key_q <= cfg_data[kmpc_pkg::LEVEL_W-1:0];
				kmpc_pkg::REG_WINDOW:      window_q <= cfg_data[kmpc_pkg::LEVEL_W-1:0];
				kmpc_pkg::REG_TIMEOUT:     timeout_q <= cfg_data;
				kmpc_pkg::REG_FAST_DUTY:   fast_duty_q <= cfg_data[kmpc_pkg::DUTY_W-1:0];
				kmpc_pkg::REG_MEDIUM_DUTY: medium_duty_q <= cfg_data[kmpc_pkg::DUTY_W-1:0];
				kmpc_pkg::REG_SLOW_DUTY:   slow_duty_q <= cfg_data[kmpc_pkg::DUTY_W-1:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			tick_div_q  <= '0;
			ms_q        <= '0;
			idle_sec_q  <= '0;
			mode_q      <= kmpc_pkg::SPEED_MEDIUM;
			mode_held_q <= 1'b0;
			fwd_cmp_q   <= kmpc_pkg::DUTY_OFF;
			rev_cmp_q   <= kmpc_pkg::DUTY_OFF;
			led_q       <= 1'b0;
			power_cut_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance) begin
				out_valid_q <= 1'b1;
				tick_div_q  <= tick_div_d;
				ms_q        <= ms_d;
				idle_sec_q  <= idle_sec_d;
				mode_q      <= mode_d;
				mode_held_q <= mode_held_d;
				fwd_cmp_q   <= fwd_cmp_d;
				rev_cmp_q   <= rev_cmp_d;
				led_q       <= led_d;
				power_cut_q <= power_cut_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input payload register: hold while the stage is stalled
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= kmpc_pkg::cmd_t'(s_tuser[0]);
			adc_s1 <= s_tdata[kmpc_pkg::LEVEL_W-1:0];
		end
	end

	// Checks
	a_power_latch: assert property (@(posedge clk) disable iff (!arst_n)
		power_cut_q |=> power_cut_q)
		else $error("power-off latch cleared");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> $stable(m_tdata) && out_valid_q)
		else $error("result changed while stalled");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(adc_s1) && $stable(cmd_s1))
		else $error("input stage lost a transaction");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_div_q < kmpc_pkg::DIV_W'(kmpc_pkg::TICKS_PER_MS))
		else $error("tick divider out of range");

	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		ms_q < kmpc_pkg::MS_W'(kmpc_pkg::MS_PER_SECOND))
		else $error("millisecond count out of range");

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for keyed_motor_pwm_controller_unit: keypad and tick stream in,
// status stream out, each transaction checked against its table row or an in-bench model of the unit.
// Depends on kmpc_pkg and the unit itself.

module testbench;

	typedef struct packed {
		logic [kmpc_pkg::DUTY_W-1:0] fwd;
		logic [kmpc_pkg::DUTY_W-1:0] rev;
		logic                        led;
		logic                        power;
		kmpc_pkg::mode_t             mode;
	} motor_status_t;

	typedef struct packed {
		kmpc_pkg::cmd_t               cmd;
		logic [kmpc_pkg::LEVEL_W-1:0] adc;
		logic                         typed;
		motor_status_t                want;
	} probe_row_t;

	localparam motor_status_t STATUS_RESET =
		'{kmpc_pkg::DUTY_OFF, kmpc_pkg::DUTY_OFF, 1'b0, 1'b0, kmpc_pkg::SPEED_MEDIUM};
	localparam motor_status_t STATUS_SLOW_IDLE =
		'{kmpc_pkg::DUTY_OFF, kmpc_pkg::DUTY_OFF, 1'b0, 1'b0, kmpc_pkg::SPEED_SLOW};
	localparam motor_status_t STATUS_SLOW_FWD =
		'{kmpc_pkg::SLOW_DUTY_RST, kmpc_pkg::DUTY_OFF, 1'b0, 1'b0, kmpc_pkg::SPEED_SLOW};
	localparam motor_status_t NO_STATUS = '0;
	localparam int FIRST_UNUSED_INDEX = kmpc_pkg::REG_SLOW_DUTY + 1;
	localparam int PROBE_COUNT = 25;

	// Rows with typed=1 carry their status; the others are left to the model
	localparam probe_row_t PROBES [0:PROBE_COUNT-1] = '{
		'{kmpc_pkg::CMD_TICK,   10'd0,    1'b1, STATUS_RESET},
		'{kmpc_pkg::CMD_SAMPLE, 10'd0,    1'b1, STATUS_RESET},
		'{kmpc_pkg::CMD_SAMPLE, 10'd1023, 1'b1, STATUS_RESET},
		'{kmpc_pkg::CMD_SAMPLE, 10'd605,  1'b1, STATUS_SLOW_IDLE},
		'{kmpc_pkg::CMD_SAMPLE, 10'd605,  1'b1, STATUS_SLOW_IDLE},
		'{kmpc_pkg::CMD_SAMPLE, 10'd344,  1'b1, STATUS_SLOW_FWD},
		'{kmpc_pkg::CMD_SAMPLE, 10'd186,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'd655,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'd554,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'd555,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'd394,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'd395,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'd136,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'd135,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'd605,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'd0,    1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'd605,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_TICK,   10'd0,    1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_TICK,   10'd1023, 1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_TICK,   10'd0,    1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_TICK,   10'd0,    1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_TICK,   10'd0,    1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'h2AA,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_SAMPLE, 10'h155,  1'b0, NO_STATUS},
		'{kmpc_pkg::CMD_TICK,   10'h3FF,  1'b0, NO_STATUS}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [kmpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [kmpc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	keyed_motor_pwm_controller_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Model copy of the registers
	logic [kmpc_pkg::LEVEL_W-1:0]   mode_level = kmpc_pkg::MODE_KEY_RST;
	logic [kmpc_pkg::LEVEL_W-1:0]   fwd_level = kmpc_pkg::FWD_KEY_RST;
	logic [kmpc_pkg::LEVEL_W-1:0]   rev_level = kmpc_pkg::REV_KEY_RST;
	logic [kmpc_pkg::LEVEL_W-1:0]   key_window = kmpc_pkg::WINDOW_RST;
	logic [kmpc_pkg::TIMEOUT_W-1:0] idle_limit = kmpc_pkg::TIMEOUT_RST;
	logic [kmpc_pkg::DUTY_W-1:0]    fast_duty = kmpc_pkg::FAST_DUTY_RST;
	logic [kmpc_pkg::DUTY_W-1:0]    medium_duty = kmpc_pkg::MEDIUM_DUTY_RST;
	logic [kmpc_pkg::DUTY_W-1:0]    slow_duty = kmpc_pkg::SLOW_DUTY_RST;

	// Model copy of the state
	logic [kmpc_pkg::DIV_W-1:0]     tick_div = '0;
	logic [kmpc_pkg::MS_W-1:0]      ms_count = '0;
	logic [kmpc_pkg::TIMEOUT_W-1:0] idle_secs = '0;
	kmpc_pkg::mode_t                cur_mode = kmpc_pkg::SPEED_MEDIUM;
	logic                           mode_held = 1'b0;
	logic [kmpc_pkg::DUTY_W-1:0]    fwd_cmp = kmpc_pkg::DUTY_OFF;
	logic [kmpc_pkg::DUTY_W-1:0]    rev_cmp = kmpc_pkg::DUTY_OFF;
	logic                           led_lvl = 1'b0;
	logic                           power_latched = 1'b0;

	motor_status_t pending_status [$];
	int  mismatches = 0;
	int  rx_wait = 0;
	bit  tx_calm = 1'b0;
	bit  rx_calm = 1'b0;
	int  last_key = 0;

	function automatic bit near_level(input logic [kmpc_pkg::LEVEL_W-1:0] s,
			input logic [kmpc_pkg::LEVEL_W-1:0] lvl);
		int d;
		d = (s >= lvl) ? int'(s) - int'(lvl) : int'(lvl) - int'(s);
		return d <= int'(key_window);
	endfunction

	function automatic logic [kmpc_pkg::DUTY_W-1:0] duty_of(input kmpc_pkg::mode_t m);
		case (m)
			kmpc_pkg::SPEED_FAST:   return fast_duty;
			kmpc_pkg::SPEED_MEDIUM: return medium_duty;
			default:                return slow_duty;
		endcase
	endfunction

	task automatic apply_register(input logic [kmpc_pkg::CFG_INDEX_W-1:0] idx,
			input logic [15:0] value);
		case (kmpc_pkg::reg_idx_t'(idx))
			kmpc_pkg::REG_MODE_KEY:    mode_level = value[kmpc_pkg::LEVEL_W-1:0];
			kmpc_pkg::REG_FWD_KEY:     fwd_level = value[kmpc_pkg::LEVEL_W-1:0];
			kmpc_pkg::REG_REV_KEY:     rev_level = value[kmpc_pkg::LEVEL_W-1:0];
			kmpc_pkg::REG_WINDOW:      key_window = value[kmpc_pkg::LEVEL_W-1:0];
			kmpc_pkg::REG_TIMEOUT:     idle_limit = value;
			kmpc_pkg::REG_FAST_DUTY:   fast_duty = value[kmpc_pkg::DUTY_W-1:0];
			kmpc_pkg::REG_MEDIUM_DUTY: medium_duty = value[kmpc_pkg::DUTY_W-1:0];
			kmpc_pkg::REG_SLOW_DUTY:   slow_duty = value[kmpc_pkg::DUTY_W-1:0];
			default: ;
		endcase
	endtask

	task automatic advance_controller(input kmpc_pkg::cmd_t cmd,
			input logic [kmpc_pkg::LEVEL_W-1:0] adc, output motor_status_t status);
		if (cmd == kmpc_pkg::CMD_TICK) begin
			tick_div = tick_div + 1'b1;
			if (tick_div >= kmpc_pkg::TICKS_PER_MS) begin
				tick_div = '0;
				ms_count = ms_count + 1'b1;
				case (cur_mode)
					kmpc_pkg::SPEED_FAST: led_lvl = 1'b1;
					kmpc_pkg::SPEED_MEDIUM: begin
						if (ms_count % kmpc_pkg::MEDIUM_BLINK_MS == 0)
							led_lvl = ~led_lvl;
					end
					kmpc_pkg::SPEED_SLOW: begin
						if (ms_count % kmpc_pkg::SLOW_BLINK_MS == 0)
							led_lvl = ~led_lvl;
					end
					default: ;
				endcase
			end
			if (ms_count >= kmpc_pkg::MS_PER_SECOND) begin
				ms_count = '0;
				if (idle_secs != kmpc_pkg::SECONDS_MAX)
					idle_secs = idle_secs + 1'b1;
			end
			if (idle_secs >= idle_limit)
				power_latched = 1'b1;
		end else begin
			// Mode key first, so a drive key on the same sample sees the new mode
			if (near_level(adc, mode_level)) begin
				if (!mode_held)
					cur_mode = (cur_mode == kmpc_pkg::SPEED_SLOW) ? kmpc_pkg::SPEED_FAST :
						kmpc_pkg::mode_t'(cur_mode + 1'b1);
				mode_held = 1'b1;
			end else begin
				mode_held = 1'b0;
			end
			if (near_level(adc, fwd_level)) begin
				fwd_cmp = duty_of(cur_mode);
				idle_secs = '0;
			end else if (near_level(adc, rev_level)) begin
				rev_cmp = duty_of(cur_mode);
				idle_secs = '0;
			end else begin
				fwd_cmp = kmpc_pkg::DUTY_OFF;
				rev_cmp = kmpc_pkg::DUTY_OFF;
			end
		end
		status = '{fwd_cmp, rev_cmp, led_lvl, power_latched, cur_mode};
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic check_status(input logic [23:0] data);
		motor_status_t want;
		if (pending_status.size() == 0) begin
			report_mismatch($sformatf("status 0x%06h with nothing pending", data));
		end else begin
			want = pending_status.pop_front();
			if (data[7:0] !== want.fwd)
				report_mismatch($sformatf("forward_duty %0d, want %0d", data[7:0], want.fwd));
			if (data[15:8] !== want.rev)
				report_mismatch($sformatf("reverse_duty %0d, want %0d", data[15:8], want.rev));
			if (data[16] !== want.led)
				report_mismatch($sformatf("led_on %0b, want %0b", data[16], want.led));
			if (data[17] !== want.power)
				report_mismatch($sformatf("power_off %0b, want %0b", data[17], want.power));
			if (data[19:18] !== want.mode)
				report_mismatch($sformatf("current_mode %0d, want %0d", data[19:18], want.mode));
		end
	endtask

	// Output side: check each transaction, then hold tready low for a drawn stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				check_status(m_tdata);
				if ($urandom_range(0, 99) < 3)
					rx_calm = !rx_calm;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 9);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_tready <= (rx_wait == 0);
		end
	end

	task automatic send_item(input kmpc_pkg::cmd_t cmd, input logic [kmpc_pkg::LEVEL_W-1:0] adc,
			input logic typed, input motor_status_t typed_status);
		int gap;
		motor_status_t want;
		if ($urandom_range(0, 99) < 3)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, adc};
		do @(posedge clk); while (!s_tready);
		advance_controller(cmd, adc, want);
		pending_status.push_back(typed ? typed_status : want);
	endtask

	// Aim near a key level most of the time, repeating the key to form holds
	function automatic logic [kmpc_pkg::LEVEL_W-1:0] pick_sample();
		int lvl;
		int w;
		int off;
		int roll;
		if ($urandom_range(0, 99) < 15)
			return kmpc_pkg::LEVEL_W'($urandom_range(0, 1023));
		if ($urandom_range(0, 1) == 0)
			last_key = $urandom_range(0, 3);
		case (last_key)
			0: lvl = mode_level;
			1: lvl = fwd_level;
			2: lvl = rev_level;
			default: return kmpc_pkg::LEVEL_W'($urandom_range(0, 1023));
		endcase
		w = key_window;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			off = w;
		else if (roll < 30)
			off = w + 1;
		else
			off = $urandom_range(0, w);
		if ($urandom_range(0, 1) == 0)
			off = -off;
		off = lvl + off;
		if (off < 0)
			off = 0;
		if (off > 1023)
			off = 1023;
		return kmpc_pkg::LEVEL_W'(off);
	endfunction

	task automatic random_run(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 40)
				send_item(kmpc_pkg::CMD_TICK, kmpc_pkg::LEVEL_W'($urandom_range(0, 1023)),
					1'b0, NO_STATUS);
			else
				send_item(kmpc_pkg::CMD_SAMPLE, pick_sample(), 1'b0, NO_STATUS);
		end
	endtask

	// Press and release the mode key until the model sits in the wanted mode
	task automatic select_mode(input kmpc_pkg::mode_t target);
		while (cur_mode != target) begin
			send_item(kmpc_pkg::CMD_SAMPLE, mode_level ^ 10'h200, 1'b0, NO_STATUS);
			send_item(kmpc_pkg::CMD_SAMPLE, mode_level, 1'b0, NO_STATUS);
		end
	endtask

	// Unbroken tick run: over a thousand ticks carry the count past a blink point
	task automatic run_ticks(input int count);
		for (int i = 0; i < count; i++)
			send_item(kmpc_pkg::CMD_TICK, kmpc_pkg::LEVEL_W'($urandom_range(0, 1023)),
				1'b0, NO_STATUS);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [kmpc_pkg::CFG_INDEX_W-1:0] idx,
			input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		apply_register(idx, value);
	endtask

	task automatic load_settings(input int mode_l, input int fwd_l, input int rev_l,
			input int win, input int tmo, input int fd, input int md, input int sd);
		write_register(kmpc_pkg::REG_MODE_KEY, 16'(mode_l));
		write_register(kmpc_pkg::REG_FWD_KEY, 16'(fwd_l));
		write_register(kmpc_pkg::REG_REV_KEY, 16'(rev_l));
		write_register(kmpc_pkg::REG_WINDOW, 16'(win));
		write_register(kmpc_pkg::REG_TIMEOUT, 16'(tmo));
		write_register(kmpc_pkg::REG_FAST_DUTY, 16'(fd));
		write_register(kmpc_pkg::REG_MEDIUM_DUTY, 16'(md));
		write_register(kmpc_pkg::REG_SLOW_DUTY, 16'(sd));
		// An unused index must leave every register alone
		write_register(kmpc_pkg::CFG_INDEX_W'($urandom_range(FIRST_UNUSED_INDEX,
			2**kmpc_pkg::CFG_INDEX_W - 1)), 16'($urandom_range(0, 65535)));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (PROBES[i])
			send_item(PROBES[i].cmd, PROBES[i].adc, PROBES[i].typed, PROBES[i].want);
		random_run(120);
		drain();
		random_run(80);
		drain();

		load_settings(0, 1023, 512, 0, 65535, 255, 0, 128);
		random_run(80);
		drain();

		// Every sample matches all three keys: forward must win
		load_settings(500, 520, 480, 1023, 65535, $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255));
		random_run(80);
		drain();

		// Upper data bits above a 10-bit register are junk and must be dropped
		load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535),
			int'({6'($urandom_range(0, 63)), 10'(120 - $urandom_range(0, 120))}),
			$urandom_range(1, 65535), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
		random_run(80);
		drain();

		// Medium mode ticks walk the LED across a blink point
		load_settings(int'(kmpc_pkg::MODE_KEY_RST), int'(kmpc_pkg::FWD_KEY_RST),
			int'(kmpc_pkg::REV_KEY_RST), int'(kmpc_pkg::WINDOW_RST),
			int'(kmpc_pkg::TIMEOUT_RST), int'(kmpc_pkg::FAST_DUTY_RST),
			int'(kmpc_pkg::MEDIUM_DUTY_RST), int'(kmpc_pkg::SLOW_DUTY_RST));
		select_mode(kmpc_pkg::SPEED_MEDIUM);
		run_ticks(1050);
		drain();

		// Zero timeout latches power-off at the next tick; drive keys keep working
		load_settings(int'(kmpc_pkg::MODE_KEY_RST), int'(kmpc_pkg::FWD_KEY_RST),
			int'(kmpc_pkg::REV_KEY_RST), int'(kmpc_pkg::WINDOW_RST), 0,
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		random_run(80);
		drain();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("keyed_motor_pwm_controller_unit regression: pass");
		else
			$display("keyed_motor_pwm_controller_unit regression: fail");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("keyed_motor_pwm_controller_unit regression: fail");
		$finish;
	end

endmodule
